>>> rtl/usart_rm_pkg.sv
// Shared types and constants for the USART register model core.
package usart_rm_pkg;

  // Default receive FIFO depth in bytes.
  localparam int FIFO_DEPTH_DEF = 256;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_HOST  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  // Register byte offsets.
  localparam logic [7:0] OFF_STATUS = 8'h00;
  localparam logic [7:0] OFF_DATA   = 8'h04;
  localparam logic [7:0] OFF_BAUD   = 8'h08;
  localparam logic [7:0] OFF_CTRL1  = 8'h0C;
  localparam logic [7:0] OFF_CTRL2  = 8'h10;
  localparam logic [7:0] OFF_CTRL3  = 8'h14;

  // Status bits.
  localparam int         ST_RXNE_BIT = 5;
  localparam logic [31:0] ST_RXNE    = 32'h0000_0020;
  localparam logic [31:0] ST_TC      = 32'h0000_0040;
  localparam logic [31:0] ST_TXE     = 32'h0000_0080;

  // Control1 bit positions.
  localparam int C1_RE_BIT = 2;
  localparam int C1_TE_BIT = 3;
  localparam int C1_UE_BIT = 13;

endpackage

>>> rtl/usart_register_model_core.sv
// Top level of the USART register model: register file, receive FIFO and request pipeline.
//   Requests enter on the input channel (in_valid / in_ready) carrying command,
//   reg_offset, write_value and rx_byte. Every request produces exactly one
//   response on the output channel (out_valid / out_ready) carrying read_data,
//   tx_valid, tx_byte and rx_dropped.
//   Path: an accepted request waits in the input register, moves into the
//   response register when that register is free, and is taken from there.
//   Throughput: one request per cycle while the output side does not stall.
//   The input register and the response register part the two sides, so a
//   request is taken while a finished response waits to be taken.
//   Receive FIFO: a memory of FIFO_DEPTH bytes with registered reads. The two
//   oldest bytes are read ahead every cycle from the next read pointer, so a
//   data read that pops twice still has both bytes at hand. A byte written in
//   the same cycle is forwarded around the memory.
//   Reset (rst, synchronous, active high): all state registers, pointers and the fill
//   count go to zero and both channels empty. FIFO contents are not cleared;
//   the fill count guards every pop, so no clearing pass is needed.
//   Stall: when out_ready is low with a response held, the request in the
//   input register holds and no state changes; in_ready drops only once the
//   input register is also full.
module usart_register_model_core #(
  parameter int FIFO_DEPTH = usart_rm_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  reg_offset,
  input  logic [31:0] write_value,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        rx_dropped
);

  localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FIFO_DEPTH);

  // Advance a FIFO pointer with wrap at the depth.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Input register.
  logic                 s1_valid;
  usart_rm_pkg::cmd_t   s1_cmd;
  logic [7:0]           s1_off;
  logic [31:0]          s1_wv;
  logic [7:0]           s1_rb;

  // Architectural state.
  logic [31:0]       status_reg, status_next;
  logic [7:0]        data_reg, data_next;
  logic [31:0]       baud_reg, baud_next;
  logic [31:0]       control1_reg, control1_next;
  logic [31:0]       control2_reg, control2_next;
  logic [31:0]       control3_reg, control3_next;
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [FILL_W-1:0] fill, fill_next;

  // Receive FIFO memory and read-ahead.
  logic [7:0]        fifo_mem [FIFO_DEPTH];
  logic [7:0]        mem_q0, mem_q1;
  logic              byp0, byp1;
  logic [7:0]        byp_byte;
  logic [7:0]        head0, head1;
  logic [PTR_W-1:0]  raddr0, raddr1;
  logic              push;

  // Step results.
  logic [31:0] rd_val;
  logic        txv, drop;
  logic [7:0]  txb;
  logic [1:0]  pops;

  // Helpers.
  logic              out_free, fire;
  logic              ue_re, drain1, drain2, c1_drain;
  logic [7:0]        data_mid;
  logic [31:0]       status_mid;
  logic [FILL_W-1:0] fill_mid;
  logic [PTR_W-1:0]  rd_p1, rd_p2;

  // Handshake: the response register frees when empty or being taken.
  assign out_free = !out_valid || out_ready;
  assign fire     = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd <= usart_rm_pkg::cmd_t'(command);
      s1_off <= reg_offset;
      s1_wv  <= write_value;
      s1_rb  <= rx_byte;
    end
  end

  // Oldest two FIFO bytes, with forwarding of a byte written last cycle.
  assign head0 = byp0 ? byp_byte : mem_q0;
  assign head1 = byp1 ? byp_byte : mem_q1;

  assign ue_re  = control1_reg[usart_rm_pkg::C1_UE_BIT] &
                  control1_reg[usart_rm_pkg::C1_RE_BIT];
  // Drain ahead of a read or on a tick.
  assign drain1 = ue_re && !status_reg[usart_rm_pkg::ST_RXNE_BIT] && (fill != '0);
  assign data_mid   = drain1 ? head0 : data_reg;
  assign status_mid = drain1 ? (status_reg | usart_rm_pkg::ST_RXNE) : status_reg;
  assign fill_mid   = fill - FILL_W'(drain1);
  // Second drain after a data read clears RXNE.
  assign drain2 = ue_re && (fill_mid != '0);
  // Drain after a control1 write sees the new enables.
  assign c1_drain = s1_wv[usart_rm_pkg::C1_UE_BIT] && s1_wv[usart_rm_pkg::C1_RE_BIT] &&
                    !status_reg[usart_rm_pkg::ST_RXNE_BIT] && (fill != '0);

  assign rd_p1 = ptr_inc(rd_ptr);
  assign rd_p2 = ptr_inc(rd_p1);

  always_comb begin
    status_next   = status_reg;
    data_next     = data_reg;
    baud_next     = baud_reg;
    control1_next = control1_reg;
    control2_next = control2_reg;
    control3_next = control3_reg;
    wr_ptr_next   = wr_ptr;
    fill_next     = fill;
    push          = 1'b0;
    pops          = 2'd0;
    rd_val        = '0;
    txv           = 1'b0;
    txb           = '0;
    drop          = 1'b0;
    unique case (s1_cmd)
      usart_rm_pkg::CMD_READ: begin
        status_next = status_mid;
        data_next   = data_mid;
        pops        = {1'b0, drain1};
        unique case (s1_off)
          usart_rm_pkg::OFF_STATUS: rd_val = status_mid;
          usart_rm_pkg::OFF_DATA: begin
            rd_val      = {24'd0, data_mid};
            data_next   = drain2 ? (drain1 ? head1 : head0) : 8'd0;
            status_next = drain2 ? (status_mid | usart_rm_pkg::ST_RXNE)
                                 : (status_mid & ~usart_rm_pkg::ST_RXNE);
            pops        = 2'(drain1) + 2'(drain2);
          end
          usart_rm_pkg::OFF_BAUD:  rd_val = baud_reg;
          usart_rm_pkg::OFF_CTRL1: rd_val = control1_reg;
          usart_rm_pkg::OFF_CTRL2: rd_val = control2_reg;
          usart_rm_pkg::OFF_CTRL3: rd_val = control3_reg;
          default:                 rd_val = '0;
        endcase
      end
      usart_rm_pkg::CMD_WRITE: begin
        unique case (s1_off)
          usart_rm_pkg::OFF_STATUS: status_next = s1_wv;
          usart_rm_pkg::OFF_DATA: begin
            data_next   = s1_wv[7:0];
            txv         = control1_reg[usart_rm_pkg::C1_UE_BIT] &
                          control1_reg[usart_rm_pkg::C1_TE_BIT];
            txb         = txv ? s1_wv[7:0] : 8'd0;
            status_next = status_reg | usart_rm_pkg::ST_TXE | usart_rm_pkg::ST_TC;
          end
          usart_rm_pkg::OFF_BAUD: baud_next = s1_wv;
          usart_rm_pkg::OFF_CTRL1: begin
            control1_next = s1_wv;
            if (c1_drain) begin
              data_next   = head0;
              status_next = status_reg | usart_rm_pkg::ST_RXNE;
              pops        = 2'd1;
            end
          end
          usart_rm_pkg::OFF_CTRL2: control2_next = s1_wv;
          usart_rm_pkg::OFF_CTRL3: control3_next = s1_wv;
          default: ;
        endcase
      end
      usart_rm_pkg::CMD_HOST: begin
        if (fill == FILL_MAX) begin
          drop = 1'b1;
        end else begin
          push        = 1'b1;
          wr_ptr_next = ptr_inc(wr_ptr);
          fill_next   = fill + FILL_W'(1);
        end
      end
      usart_rm_pkg::CMD_TICK: begin
        status_next = status_mid;
        data_next   = data_mid;
        pops        = {1'b0, drain1};
      end
      default: ;
    endcase
    fill_next   = fill_next - FILL_W'(pops);
    rd_ptr_next = (pops == 2'd2) ? rd_p2 : (pops == 2'd1) ? rd_p1 : rd_ptr;
  end

  // Read ahead from the pointer the FIFO will hold next cycle.
  assign raddr0 = fire ? rd_ptr_next : rd_ptr;
  assign raddr1 = ptr_inc(raddr0);

  always_ff @(posedge clk) begin
    if (fire && push) begin
      fifo_mem[wr_ptr] <= s1_rb;
    end
    mem_q0 <= fifo_mem[raddr0];
    mem_q1 <= fifo_mem[raddr1];
  end

  // Forward a byte written this cycle to a read-ahead slot at the same address.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp0 <= 1'b0;
      byp1 <= 1'b0;
    end else begin
      byp0 <= fire && push && (wr_ptr == raddr0);
      byp1 <= fire && push && (wr_ptr == raddr1);
    end
  end

  always_ff @(posedge clk) begin
    byp_byte <= s1_rb;
  end

  // Commit state on each processed request.
  always_ff @(posedge clk) begin
    if (rst) begin
      status_reg   <= '0;
      data_reg     <= '0;
      baud_reg     <= '0;
      control1_reg <= '0;
      control2_reg <= '0;
      control3_reg <= '0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      fill         <= '0;
    end else if (fire) begin
      status_reg   <= status_next;
      data_reg     <= data_next;
      baud_reg     <= baud_next;
      control1_reg <= control1_next;
      control2_reg <= control2_next;
      control3_reg <= control3_next;
      wr_ptr       <= wr_ptr_next;
      rd_ptr       <= rd_ptr_next;
      fill         <= fill_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data  <= rd_val;
      tx_valid   <= txv;
      tx_byte    <= txb;
      rx_dropped <= drop;
    end
  end

  // Fill count never exceeds the FIFO depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("receive FIFO fill count above depth");

  // Empty or full FIFO has both pointers at the same place.
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (fill == '0 || fill == FILL_MAX) |-> (wr_ptr == rd_ptr))
    else $error("FIFO pointers disagree with fill count");

  // A stalled response freezes the FIFO.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(fill) && $stable(rd_ptr)))
    else $error("FIFO state changed during output stall");

  // A dropped host byte never comes with a read value or a sent byte.
  a_drop_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rx_dropped) |-> (read_data == '0 && !tx_valid))
    else $error("dropped byte response carries other results");

endmodule

>>> bench/tb_usart_register_model_core.sv
// Self-checking testbench for the USART register model core: registers, transmit and receive FIFO.
`timescale 1ns / 100ps

module tb_usart_register_model_core;

  localparam int          RX_DEPTH    = usart_rm_pkg::FIFO_DEPTH_DEF;
  localparam int          RX_PTR_W    = $clog2(RX_DEPTH);
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Offsets outside the register map.
  localparam logic [7:0] OFF_UNMAPPED_TOP = 8'hFF;
  localparam logic [7:0] OFF_UNMAPPED_MID = 8'h80;

  // Control1 settings used by the directed tests.
  localparam logic [31:0] CTRL1_RX_ON  = (32'd1 << usart_rm_pkg::C1_UE_BIT) |
                                         (32'd1 << usart_rm_pkg::C1_RE_BIT);
  localparam logic [31:0] CTRL1_ALL_ON = CTRL1_RX_ON | (32'd1 << usart_rm_pkg::C1_TE_BIT);

  // One response as the block returns it.
  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_dropped;
  } usart_resp_t;

  logic                clk;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  usart_rm_pkg::cmd_t  command     = usart_rm_pkg::CMD_READ;
  logic [7:0]          reg_offset  = '0;
  logic [31:0]         write_value = '0;
  logic [7:0]          rx_byte     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [31:0]         read_data;
  logic                tx_valid;
  logic [7:0]          tx_byte;
  logic                rx_dropped;

  usart_register_model_core #(
    .FIFO_DEPTH(RX_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .reg_offset (reg_offset),
    .write_value(write_value),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .tx_valid   (tx_valid),
    .tx_byte    (tx_byte),
    .rx_dropped (rx_dropped)
  );

  // Responses owed by the block, oldest first.
  usart_resp_t expected_responses[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Idle controls for both sides; the tests flip them between phases.
  bit          sender_idles    = 1'b1;
  bit          receiver_stalls = 1'b1;
  int unsigned stall_left      = 0;

  // Shadow copy of the register file and receive FIFO.
  logic [31:0] shadow_status = '0;
  logic [7:0]  shadow_data   = '0;
  logic [31:0] shadow_baud   = '0;
  logic [31:0] shadow_ctrl1  = '0;
  logic [31:0] shadow_ctrl2  = '0;
  logic [31:0] shadow_ctrl3  = '0;
  logic [7:0]  shadow_fifo [RX_DEPTH];
  int unsigned shadow_wr_ptr = 0;
  int unsigned shadow_rd_ptr = 0;
  int unsigned shadow_fill   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hold reset from the start, then release it for good.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Stall the response side in random bursts while stalls are enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (receiver_stalls && $urandom_range(99) < 25) begin
      stall_left <= idle_length();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Move the oldest FIFO byte into the data register when the receiver is on
  // and the data register is free.
  function automatic void move_rx_to_data();
    if (!shadow_ctrl1[usart_rm_pkg::C1_UE_BIT] || !shadow_ctrl1[usart_rm_pkg::C1_RE_BIT])
      return;
    if (shadow_status[usart_rm_pkg::ST_RXNE_BIT] || shadow_fill == 0) return;
    shadow_data   = shadow_fifo[RX_PTR_W'(shadow_rd_ptr)];
    shadow_rd_ptr = (shadow_rd_ptr + 1) % RX_DEPTH;
    shadow_fill   = shadow_fill - 1;
    shadow_status = shadow_status | usart_rm_pkg::ST_RXNE;
  endfunction

  // Advance the shadow state by one request and return the response it owes.
  function automatic usart_resp_t predict_response(usart_rm_pkg::cmd_t cmd, logic [7:0] off,
                                                   logic [31:0] wv, logic [7:0] rb);
    usart_resp_t resp;
    resp = '0;
    case (cmd)
      usart_rm_pkg::CMD_READ: begin
        // Every read drains first, even at an unmapped offset.
        move_rx_to_data();
        case (off)
          usart_rm_pkg::OFF_STATUS: resp.read_data = shadow_status;
          usart_rm_pkg::OFF_DATA: begin
            // Hand out the byte, free the data register and refill it.
            resp.read_data = {24'h0, shadow_data};
            shadow_status  = shadow_status & ~usart_rm_pkg::ST_RXNE;
            shadow_data    = '0;
            move_rx_to_data();
          end
          usart_rm_pkg::OFF_BAUD:  resp.read_data = shadow_baud;
          usart_rm_pkg::OFF_CTRL1: resp.read_data = shadow_ctrl1;
          usart_rm_pkg::OFF_CTRL2: resp.read_data = shadow_ctrl2;
          usart_rm_pkg::OFF_CTRL3: resp.read_data = shadow_ctrl3;
          default:                 resp.read_data = '0;
        endcase
      end
      usart_rm_pkg::CMD_WRITE: begin
        case (off)
          // The whole word lands in status, RXNE included.
          usart_rm_pkg::OFF_STATUS: shadow_status = wv;
          usart_rm_pkg::OFF_DATA: begin
            shadow_data = wv[7:0];
            if (shadow_ctrl1[usart_rm_pkg::C1_UE_BIT] &&
                shadow_ctrl1[usart_rm_pkg::C1_TE_BIT]) begin
              resp.tx_valid = 1'b1;
              resp.tx_byte  = wv[7:0];
            end
            shadow_status = shadow_status | usart_rm_pkg::ST_TXE | usart_rm_pkg::ST_TC;
          end
          usart_rm_pkg::OFF_BAUD: shadow_baud = wv;
          usart_rm_pkg::OFF_CTRL1: begin
            shadow_ctrl1 = wv;
            move_rx_to_data();
          end
          usart_rm_pkg::OFF_CTRL2: shadow_ctrl2 = wv;
          usart_rm_pkg::OFF_CTRL3: shadow_ctrl3 = wv;
          default: ;
        endcase
      end
      usart_rm_pkg::CMD_HOST: begin
        // Push only; a full FIFO drops the byte and flags it.
        if (shadow_fill >= RX_DEPTH) begin
          resp.rx_dropped = 1'b1;
        end else begin
          shadow_fifo[RX_PTR_W'(shadow_wr_ptr)] = rb;
          shadow_wr_ptr = (shadow_wr_ptr + 1) % RX_DEPTH;
          shadow_fill   = shadow_fill + 1;
        end
      end
      default: move_rx_to_data();
    endcase
    return resp;
  endfunction

  // Compare each response with the oldest one owed.
  always @(posedge clk) begin : check_responses
    usart_resp_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_responses.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        want = expected_responses.pop_front();
        if (read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, read_data);
          mismatches++;
        end
        if (tx_valid !== want.tx_valid) begin
          $error("tx_valid: expected %b, got %b", want.tx_valid, tx_valid);
          mismatches++;
        end
        if (tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %h, got %h", want.tx_byte, tx_byte);
          mismatches++;
        end
        if (rx_dropped !== want.rx_dropped) begin
          $error("rx_dropped: expected %b, got %b", want.rx_dropped, rx_dropped);
          mismatches++;
        end
      end
    end
  end

  // Offer one request, hold it until accepted, then log its expected response.
  // Valid stays high into the next request when no gap follows.
  task automatic send_request(input usart_rm_pkg::cmd_t cmd, input logic [7:0] off,
                              input logic [31:0] wv, input logic [7:0] rb);
    int unsigned idle;
    idle = sender_idles ? idle_length() : 0;
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    reg_offset  <= off;
    write_value <= wv;
    rx_byte     <= rb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_responses.push_back(predict_response(cmd, off, wv, rb));
  endtask

  // Drop valid and wait until every owed response has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  // Mostly a mapped register, sometimes any offset.
  function automatic logic [7:0] random_offset();
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    case ($urandom_range(5))
      0:       return usart_rm_pkg::OFF_STATUS;
      1:       return usart_rm_pkg::OFF_DATA;
      2:       return usart_rm_pkg::OFF_BAUD;
      3:       return usart_rm_pkg::OFF_CTRL1;
      4:       return usart_rm_pkg::OFF_CTRL2;
      default: return usart_rm_pkg::OFF_CTRL3;
    endcase
  endfunction

  // Control1 word that usually turns the port and receiver on.
  function automatic logic [31:0] ctrl1_value();
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(99) < 80) begin
      v[usart_rm_pkg::C1_UE_BIT] = 1'b1;
      v[usart_rm_pkg::C1_RE_BIT] = 1'b1;
    end
    return v;
  endfunction

  task automatic send_random_request();
    usart_rm_pkg::cmd_t cmd;
    logic [7:0]         off;
    logic [31:0]        wv;
    int unsigned        roll;
    roll = $urandom_range(99);
    off  = random_offset();
    wv   = $urandom();
    if (roll < 30) begin
      cmd = usart_rm_pkg::CMD_HOST;
    end else if (roll < 65) begin
      cmd = usart_rm_pkg::CMD_READ;
      if ($urandom_range(1) == 1) off = usart_rm_pkg::OFF_DATA;
    end else if (roll < 85) begin
      cmd = usart_rm_pkg::CMD_WRITE;
      if (off == usart_rm_pkg::OFF_CTRL1) wv = ctrl1_value();
    end else begin
      cmd = usart_rm_pkg::CMD_TICK;
    end
    send_request(cmd, off, wv, 8'($urandom_range(255)));
  endtask

  // Reset values, full-scale writes, unmapped reads and writes.
  task automatic test_register_file();
    send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_STATUS, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_DATA, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_BAUD, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_CTRL1, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_CTRL2, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_CTRL3, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_READ, OFF_UNMAPPED_TOP, 32'hFFFF_FFFF, 8'hFF);
    send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_BAUD, 32'hFFFF_FFFF, 8'h00);
    send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_CTRL2, 32'hFFFF_FFFF, 8'h00);
    send_request(usart_rm_pkg::CMD_WRITE, OFF_UNMAPPED_TOP, 32'hFFFF_FFFF, 8'hFF);
    send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_BAUD, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_CTRL2, 32'h0, 8'h00);
  endtask

  // Host bytes wait while the receiver is off, then drain in order.
  // A status write with RXNE set blocks the drain; an unmapped read does not drain past it.
  task automatic test_receive_path();
    send_request(usart_rm_pkg::CMD_HOST, 8'h00, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_HOST, 8'h00, 32'h0, 8'hFF);
    send_request(usart_rm_pkg::CMD_TICK, 8'h00, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_CTRL1, CTRL1_RX_ON, 8'h00);
    send_request(usart_rm_pkg::CMD_HOST, 8'h00, 32'h0, 8'h5A);
    send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_STATUS, 32'hFFFF_FFFF, 8'h00);
    send_request(usart_rm_pkg::CMD_READ, OFF_UNMAPPED_MID, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_DATA, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_DATA, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_STATUS, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_DATA, 32'h0, 8'h00);
  endtask

  // Data writes go out on the line only with transmit enabled.
  task automatic test_transmit();
    send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_DATA, 32'h0000_00A5, 8'h00);
    send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_CTRL1, CTRL1_ALL_ON, 8'h00);
    send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_DATA, 32'hFFFF_FF3C, 8'h00);
    send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_STATUS, 32'h0, 8'h00);
  endtask

  // Fill the FIFO with the receiver off, overflow it, then read it all back.
  task automatic test_fifo_overflow();
    int unsigned k;
    hold_until_drained();
    send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_CTRL1, 32'h0, 8'h00);
    send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_STATUS, 32'h0, 8'h00);
    for (k = 0; k < RX_DEPTH + 4; k++)
      send_request(usart_rm_pkg::CMD_HOST, random_offset(), $urandom(),
                   8'($urandom_range(255)));
    send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_CTRL1, CTRL1_RX_ON, 8'h00);
    // Read back with no idling on either side.
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    for (k = 0; k < RX_DEPTH + 2; k++)
      send_request(usart_rm_pkg::CMD_READ, usart_rm_pkg::OFF_DATA, $urandom(),
                   8'($urandom_range(255)));
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // Mixed traffic: single requests, receive bursts drained by data reads,
  // and control1 rewrites followed by transmits.
  task automatic test_random_traffic(input int unsigned quota);
    int unsigned sent;
    int unsigned next_shift;
    int unsigned burst;
    int unsigned k;
    bit          paused;
    sent       = 0;
    next_shift = 0;
    paused     = 1'b0;
    while (sent < quota) begin
      if (sent >= next_shift) begin
        sender_idles    = ($urandom_range(3) != 0);
        receiver_stalls = ($urandom_range(3) != 0);
        next_shift      = sent + $urandom_range(300, 100);
      end
      if (!paused && sent >= quota / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      case ($urandom_range(3))
        0, 1: begin
          send_random_request();
          sent++;
        end
        2: begin
          burst = $urandom_range(24, 1);
          for (k = 0; k < burst; k++)
            send_request(usart_rm_pkg::CMD_HOST, random_offset(), $urandom(),
                         8'($urandom_range(255)));
          if ($urandom_range(3) == 0)
            send_request(usart_rm_pkg::CMD_TICK, random_offset(), $urandom(),
                         8'($urandom_range(255)));
          for (k = 0; k < burst; k++)
            send_request(usart_rm_pkg::CMD_READ,
                         ($urandom_range(7) == 0) ? usart_rm_pkg::OFF_STATUS
                                                  : usart_rm_pkg::OFF_DATA,
                         $urandom(), 8'($urandom_range(255)));
          sent += 2 * burst + 1;
        end
        default: begin
          send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_CTRL1, ctrl1_value(),
                       8'($urandom_range(255)));
          burst = $urandom_range(4, 1);
          for (k = 0; k < burst; k++)
            send_request(usart_rm_pkg::CMD_WRITE, usart_rm_pkg::OFF_DATA, $urandom(),
                         8'($urandom_range(255)));
          sent += burst + 1;
        end
      endcase
    end
  endtask

  initial begin
    @(negedge rst);
    @(posedge clk);
    test_register_file();
    test_receive_path();
    test_transmit();
    test_fifo_overflow();
    test_random_traffic(1000);
    // Let the last responses drain, then watch for stray responses before the verdict.
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> usart_register_model_core.f
rtl/usart_rm_pkg.sv
rtl/usart_register_model_core.sv
bench/tb_usart_register_model_core.sv
